// ===== sv/lefe_pkg.sv =====
// lefe_pkg: shared types, effect codes, register indexes and helper functions
// for the led effect frame encoder; no dependencies
`default_nettype none

package lefe_pkg;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EFFECT_MODE = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BRIGHTNESS  = 2'd1;

   // effect codes
   localparam logic [4:0] MODE_OFF        = 5'd0;
   localparam logic [4:0] MODE_SCROLL     = 5'd1;
   localparam logic [4:0] MODE_BREATH7    = 5'd2;
   localparam logic [4:0] MODE_BR_RED     = 5'd3;
   localparam logic [4:0] MODE_BR_GREEN   = 5'd4;
   localparam logic [4:0] MODE_BR_BLUE    = 5'd5;
   localparam logic [4:0] MODE_GR_BLU_RED = 5'd6;
   localparam logic [4:0] MODE_GR_GRN_BLU = 5'd7;
   localparam logic [4:0] MODE_GR_RED_GRN = 5'd8;
   localparam logic [4:0] MODE_GR_RGB     = 5'd9;
   localparam logic [4:0] MODE_RGB_REPEAT = 5'd10;
   localparam logic [4:0] MODE_BLUE_RED   = 5'd11;
   localparam logic [4:0] MODE_BLUE       = 5'd12;
   localparam logic [4:0] MODE_GREEN_BLUE = 5'd13;
   localparam logic [4:0] MODE_GREEN      = 5'd14;
   localparam logic [4:0] MODE_RED_GREEN  = 5'd15;
   localparam logic [4:0] MODE_RED        = 5'd16;

   // brightness codes
   localparam logic [1:0] LEVEL_LOW    = 2'd0;
   localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
   localparam logic [1:0] LEVEL_HIGH   = 2'd2;

   // spi bytes per color bit
   localparam logic [7:0] SPI_ONE  = 8'hFC;
   localparam logic [7:0] SPI_ZERO = 8'hC0;

   // most leds rendered per frame
   localparam int MAX_LEDS = 8;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } rgb_type;

   // snapshot of everything the back end needs to render one frame
   typedef struct packed {
      logic [4:0] mode;
      logic [1:0] level;
      logic [7:0] breath;
      logic [2:0] position;
   } frame_desc_type;

   typedef struct packed {
      logic                       valid;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } csr_write_type;

   function automatic logic [7:0] scale_factor(input logic [1:0] level);
      logic [7:0] f;
      unique case (level)
         LEVEL_LOW:    f = 8'd13;
         LEVEL_MEDIUM: f = 8'd102;
         default:      f = 8'd255;
      endcase
      return f;
   endfunction

   // scrolling palette, index seven wraps to entry zero
   function automatic rgb_type rainbow_color(input logic [2:0] idx);
      rgb_type c;
      unique case (idx)
         3'd1:    c = '{r: 8'd255, g: 8'd127, b: 8'd0};
         3'd2:    c = '{r: 8'd255, g: 8'd255, b: 8'd0};
         3'd3:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
         3'd4:    c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
         3'd5:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
         3'd6:    c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
         default: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      endcase
      return c;
   endfunction

   // seven-color breathing palette, index seven wraps to entry zero
   function automatic rgb_type breath_color(input logic [2:0] idx);
      rgb_type c;
      unique case (idx)
         3'd1:    c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
         3'd2:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
         3'd3:    c = '{r: 8'd255, g: 8'd255, b: 8'd0};
         3'd4:    c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
         3'd5:    c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
         3'd6:    c = '{r: 8'd255, g: 8'd255, b: 8'd255};
         default: c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      endcase
      return c;
   endfunction

   // floor(p / 255), exact for products of two bytes
   function automatic logic [7:0] div255(input logic [15:0] p);
      logic [16:0] t;
      t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
      return t[15:8];
   endfunction

   // one spi byte per bit, msb first in the top byte
   function automatic logic [63:0] expand_byte(input logic [7:0] v);
      logic [63:0] p;
      for (int k = 0; k < 8; k++) begin
         p[8*k +: 8] = v[k] ? SPI_ONE : SPI_ZERO;
      end
      return p;
   endfunction

   // modulo seven step of the palette position
   function automatic logic [2:0] next_position(input logic [2:0] pos);
      return (pos >= 3'd6) ? 3'(pos - 3'd6) : 3'(pos + 3'd1);
   endfunction

endpackage

`default_nettype wire

// ===== sv/led_effect_frame_encoder_core.sv =====
// led effect frame encoder: one rendering tick yields min(NUM_LEDS, 8) items,
// one per cycle unless stalled, set by the back end's single color/scale/encode path.
// a frame's first item passes through the queue, stage one and the output register.
// a request without a frame tick is accepted but renders no frame.
// a two-deep frame queue lets one more rendering tick be taken while a frame drains.
// reset clears the queue and pipeline, sets mode off, brightness high, state zero.
`default_nettype none

module led_effect_frame_encoder_core #(
   parameter int NUM_LEDS = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_frame_tick,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [2:0]                                rsp_led_index,
   output logic [63:0]                               rsp_green_pattern,
   output logic [63:0]                               rsp_red_pattern,
   output logic [63:0]                               rsp_blue_pattern,
   output logic                                      rsp_last_led,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [lefe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [lefe_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import lefe_pkg::*;

   csr_write_type  csr_write;
   logic           queue_full, push_valid, pop, head_valid;
   frame_desc_type push_desc, head_desc;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = '{valid: csr_valid && csr_ready, index: csr_index, data: csr_data};

   lefe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_tick (req_frame_tick),
      .csr_write      (csr_write),
      .queue_full     (queue_full),
      .push_valid     (push_valid),
      .push_desc      (push_desc)
   );

   lefe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_desc  (push_desc),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_desc  (head_desc)
   );

   lefe_back #(.NUM_LEDS(NUM_LEDS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_desc         (head_desc),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_led_index     (rsp_led_index),
      .rsp_green_pattern (rsp_green_pattern),
      .rsp_red_pattern   (rsp_red_pattern),
      .rsp_blue_pattern  (rsp_blue_pattern),
      .rsp_last_led      (rsp_last_led)
   );

endmodule

`default_nettype wire

// ===== sv/lefe_front.sv =====
// lefe_front: accepts frame ticks, holds configuration and animation state,
// and pushes one frame snapshot per rendering tick; uses lefe_pkg
`default_nettype none

module lefe_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_frame_tick,
   input  wire lefe_pkg::csr_write_type csr_write,
   input  wire logic                    queue_full,
   output logic                         push_valid,
   output lefe_pkg::frame_desc_type     push_desc
);
   import lefe_pkg::*;

   logic [4:0] effect_mode_ff, effect_mode_in;
   logic [1:0] brightness_level_ff, brightness_level_in;
   logic [7:0] breath_value_ff, breath_value_in;
   logic       breath_falling_ff, breath_falling_in;
   logic [2:0] palette_position_ff, palette_position_in;
   logic       accept;
   logic [7:0] step2_up;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign push_valid = accept && req_frame_tick;
   assign push_desc  = '{mode: effect_mode_ff, level: brightness_level_ff,
                         breath: breath_value_ff, position: palette_position_ff};

   assign step2_up = (breath_value_ff >= 8'd253) ? 8'd255 : 8'(breath_value_ff + 8'd2);

   // configuration writes and per-frame animation advance
   always_comb begin
      effect_mode_in      = effect_mode_ff;
      brightness_level_in = brightness_level_ff;
      breath_value_in     = breath_value_ff;
      breath_falling_in   = breath_falling_ff;
      palette_position_in = palette_position_ff;
      if (csr_write.valid) begin
         if (csr_write.index == CSR_EFFECT_MODE) begin
            effect_mode_in      = csr_write.data[4:0];
            breath_value_in     = 8'd0;
            breath_falling_in   = 1'b0;
            palette_position_in = 3'd0;
         end else if (csr_write.index == CSR_BRIGHTNESS) begin
            brightness_level_in = csr_write.data[1:0];
         end
      end else if (push_valid) begin
         priority if (effect_mode_ff == MODE_SCROLL) begin
            palette_position_in = next_position(palette_position_ff);
         end else if (effect_mode_ff == MODE_BREATH7) begin
            priority if (!breath_falling_ff) begin
               breath_value_in   = step2_up;
               breath_falling_in = (step2_up == 8'd255);
            end else if (breath_value_ff <= 8'd2) begin
               breath_value_in     = 8'd0;
               breath_falling_in   = 1'b0;
               palette_position_in = next_position(palette_position_ff);
            end else begin
               breath_value_in = 8'(breath_value_ff - 8'd2);
            end
         end else if (effect_mode_ff >= MODE_BR_RED && effect_mode_ff <= MODE_GR_RGB) begin
            if (!breath_falling_ff) begin
               if (breath_value_ff != 8'd255) breath_value_in = 8'(breath_value_ff + 8'd1);
               breath_falling_in = (breath_value_ff >= 8'd254);
            end else begin
               if (breath_value_ff != 8'd0) breath_value_in = 8'(breath_value_ff - 8'd1);
               breath_falling_in = !(breath_value_ff <= 8'd1);
            end
         end else begin
            // static and unused modes keep their state
            breath_value_in = breath_value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         effect_mode_ff      <= MODE_OFF;
         brightness_level_ff <= LEVEL_HIGH;
         breath_value_ff     <= 8'd0;
         breath_falling_ff   <= 1'b0;
         palette_position_ff <= 3'd0;
      end else begin
         effect_mode_ff      <= effect_mode_in;
         brightness_level_ff <= brightness_level_in;
         breath_value_ff     <= breath_value_in;
         breath_falling_ff   <= breath_falling_in;
         palette_position_ff <= palette_position_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lefe_queue.sv =====
// lefe_queue: two-entry queue of frame snapshots between front and back end;
// uses lefe_pkg
`default_nettype none

module lefe_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   input  wire lefe_pkg::frame_desc_type push_desc,
   output logic                          full,
   input  wire logic                     pop,
   output logic                          head_valid,
   output lefe_pkg::frame_desc_type      head_desc
);
   import lefe_pkg::*;

   frame_desc_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = 2'(count_ff + 2'd1);
      if (do_pop && !do_push) count_in = 2'(count_ff - 2'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

`default_nettype wire

// ===== sv/lefe_back.sv =====
// lefe_back: walks the leds of the queued frame, one per cycle unless stalled,
// through a color/scale stage and an encode/output stage; uses lefe_pkg
`default_nettype none

module lefe_back #(
   parameter int NUM_LEDS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     head_valid,
   input  wire lefe_pkg::frame_desc_type head_desc,
   output logic                          pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [2:0]                    rsp_led_index,
   output logic [63:0]                   rsp_green_pattern,
   output logic [63:0]                   rsp_red_pattern,
   output logic [63:0]                   rsp_blue_pattern,
   output logic                          rsp_last_led
);
   import lefe_pkg::*;

   localparam int         COUNT    = (NUM_LEDS > MAX_LEDS) ? MAX_LEDS : NUM_LEDS;
   localparam logic [2:0] LAST_IDX = 3'(COUNT - 1);

   logic [2:0]  led_ff, led_in;
   logic        advance, issue, issue_last;
   rgb_type     color;
   logic [7:0]  factor;
   logic [3:0]  scroll_sum;
   logic [2:0]  scroll_idx;
   logic [1:0]  mod3;

   logic        s1_valid_ff;
   logic [2:0]  s1_led_ff;
   logic        s1_last_ff;
   logic [15:0] s1_prod_g_ff, s1_prod_r_ff, s1_prod_b_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_led_ff;
   logic        rsp_last_ff;
   logic [63:0] rsp_green_ff, rsp_red_ff, rsp_blue_ff;

   // whole pipeline moves when the output register is free
   assign advance    = !rsp_valid_ff || rsp_ready;
   assign issue      = head_valid && advance;
   assign issue_last = (led_ff == LAST_IDX);
   assign pop        = issue && issue_last;
   assign led_in     = issue ? (issue_last ? 3'd0 : 3'(led_ff + 3'd1)) : led_ff;

   // led counter within the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff <= 3'd0;
      end else begin
         led_ff <= led_in;
      end
   end

   // palette index for scrolling, modulo seven
   assign scroll_sum = {1'b0, head_desc.position} + {1'b0, led_ff};
   assign scroll_idx = (scroll_sum >= 4'd7) ? 3'(scroll_sum - 4'd7) : scroll_sum[2:0];

   always_comb begin
      unique case (led_ff)
         3'd0, 3'd3, 3'd6: mod3 = 2'd0;
         3'd1, 3'd4, 3'd7: mod3 = 2'd1;
         default:          mod3 = 2'd2;
      endcase
   end

   // color of the current led, palette entries are full or zero so dimming
   // by the breath level is a select
   always_comb begin
      logic [7:0] v;
      rgb_type    bc;
      v     = head_desc.breath;
      bc    = breath_color(head_desc.position);
      color = '{r: 8'd0, g: 8'd0, b: 8'd0};
      unique case (head_desc.mode)
         MODE_SCROLL:     color = rainbow_color(scroll_idx);
         MODE_BREATH7:    color = '{r: (bc.r[7] ? v : 8'd0), g: (bc.g[7] ? v : 8'd0),
                                    b: (bc.b[7] ? v : 8'd0)};
         MODE_BR_RED:     color = '{r: v, g: 8'd0, b: 8'd0};
         MODE_BR_GREEN:   color = '{r: 8'd0, g: v, b: 8'd0};
         MODE_BR_BLUE:    color = '{r: 8'd0, g: 8'd0, b: v};
         MODE_GR_BLU_RED: color = '{r: v, g: 8'd0, b: ~v};
         MODE_GR_GRN_BLU: color = '{r: 8'd0, g: v, b: ~v};
         MODE_GR_RED_GRN: color = '{r: v, g: ~v, b: 8'd0};
         MODE_GR_RGB:     color = '{r: v, g: v, b: ~v};
         MODE_RGB_REPEAT: begin
            unique case (mod3)
               2'd0:    color = '{r: 8'd255, g: 8'd0, b: 8'd0};
               2'd1:    color = '{r: 8'd0, g: 8'd255, b: 8'd0};
               default: color = '{r: 8'd0, g: 8'd0, b: 8'd255};
            endcase
         end
         MODE_BLUE_RED:   color = led_ff[0] ? '{r: 8'd255, g: 8'd0, b: 8'd0}
                                            : '{r: 8'd0, g: 8'd0, b: 8'd255};
         MODE_BLUE:       color = '{r: 8'd0, g: 8'd0, b: 8'd255};
         MODE_GREEN_BLUE: color = led_ff[0] ? '{r: 8'd0, g: 8'd0, b: 8'd255}
                                            : '{r: 8'd0, g: 8'd255, b: 8'd0};
         MODE_GREEN:      color = '{r: 8'd0, g: 8'd255, b: 8'd0};
         MODE_RED_GREEN:  color = led_ff[0] ? '{r: 8'd0, g: 8'd255, b: 8'd0}
                                            : '{r: 8'd255, g: 8'd0, b: 8'd0};
         MODE_RED:        color = '{r: 8'd255, g: 8'd0, b: 8'd0};
         default:         color = '{r: 8'd0, g: 8'd0, b: 8'd0};
      endcase
   end

   assign factor = scale_factor(head_desc.level);

   // stage one: brightness products
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_led_ff    <= led_ff;
         s1_last_ff   <= issue_last;
         s1_prod_g_ff <= 16'(color.g) * 16'(factor);
         s1_prod_r_ff <= 16'(color.r) * 16'(factor);
         s1_prod_b_ff <= 16'(color.b) * 16'(factor);
      end
   end

   // stage two: divide by 255, expand to spi bytes, hold for the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_led_ff   <= s1_led_ff;
         rsp_last_ff  <= s1_last_ff;
         rsp_green_ff <= expand_byte(div255(s1_prod_g_ff));
         rsp_red_ff   <= expand_byte(div255(s1_prod_r_ff));
         rsp_blue_ff  <= expand_byte(div255(s1_prod_b_ff));
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_led_index     = rsp_led_ff;
   assign rsp_last_led      = rsp_last_ff;
   assign rsp_green_pattern = rsp_green_ff;
   assign rsp_red_pattern   = rsp_red_ff;
   assign rsp_blue_pattern  = rsp_blue_ff;

endmodule

`default_nettype wire

// ===== sv/lefe_checker.sv =====
// lefe_checker: port-level assertions on the encoder's result stream, and the
// bind that attaches them to led_effect_frame_encoder_core; no dependencies
`default_nettype none

module lefe_checker #(
   parameter int NUM_LEDS = 8
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_led_index,
   input wire logic [63:0] rsp_green_pattern,
   input wire logic [63:0] rsp_red_pattern,
   input wire logic [63:0] rsp_blue_pattern,
   input wire logic        rsp_last_led
);
   localparam int         COUNT    = (NUM_LEDS > 8) ? 8 : NUM_LEDS;
   localparam logic [2:0] LAST_IDX = 3'(COUNT - 1);
   localparam logic [63:0] FIXED_MASK = 64'hC3C3_C3C3_C3C3_C3C3;
   localparam logic [63:0] FIXED_BITS = 64'hC0C0_C0C0_C0C0_C0C0;

   logic [2:0] exp_led_ff, exp_led_in;

   // led position expected on the next item
   assign exp_led_in = (rsp_valid && rsp_ready) ?
                       (rsp_last_led ? 3'd0 : 3'(rsp_led_index + 3'd1)) : exp_led_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_led_ff <= 3'd0;
      end else begin
         exp_led_ff <= exp_led_in;
      end
   end

   // no item right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled item holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_index) &&
      $stable(rsp_green_pattern) && $stable(rsp_red_pattern) &&
      $stable(rsp_blue_pattern) && $stable(rsp_last_led))
      else $error("stalled result changed");

   // leds come in order from zero within each frame
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_led_index == exp_led_ff)
      else $error("led index out of order");

   // frame end marker sits on the last led only
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last_led == (rsp_led_index == LAST_IDX))
      else $error("last led flag wrong");

   // every spi byte has the fixed bits that both bit codes share
   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_green_pattern & FIXED_MASK) == FIXED_BITS &&
      (rsp_red_pattern & FIXED_MASK) == FIXED_BITS &&
      (rsp_blue_pattern & FIXED_MASK) == FIXED_BITS)
      else $error("bad spi byte code");

endmodule

bind led_effect_frame_encoder_core lefe_checker #(.NUM_LEDS(NUM_LEDS)) u_lefe_checker (.*);

`default_nettype wire
